// ===== hdl/lgs_pkg.sv =====
package lgs_pkg;

    typedef enum logic [1:0] {
        REQ_WRITE   = 2'd0,
        REQ_READ    = 2'd1,
        REQ_ADVANCE = 2'd2,
        REQ_CLEAR   = 2'd3
    } t_req;

    typedef enum logic [6:0] {
        S_INIT      = 7'b0000001,
        S_IDLE      = 7'b0000010,
        S_CELL      = 7'b0000100,
        S_GEN_PRIME = 7'b0001000,
        S_GEN_RUN   = 7'b0010000,
        S_CLEAR     = 7'b0100000,
        S_FINISH    = 7'b1000000
    } t_state;

    localparam logic [3:0] STAY_MIN    = 4'd2;
    localparam logic [3:0] BIRTH_COUNT = 4'd3;

endpackage

// ===== hdl/life_grid_generation_step.sv =====
// Bounded B3/S23 life grid of GRID_ROWS x GRID_COLS one-bit cells, one row per memory word;
// cells outside the grid count as dead. Each accepted word (write cell, read cell, advance
// one generation, clear grid) returns one word echoing the request type and, for a read,
// the cell value. Write and read go through a memory read, an update and a result step.
// Advance shares one row-update unit over all rows, one row per cycle, fed by a three-row
// window and the memory's single read port. Clear zeroes one row per cycle. After reset a
// clearing pass over all rows runs before the first word is accepted. The result sits in
// an output register, so a new word is accepted while the previous result waits; a result
// waits in turn for that register to drain.
module life_grid_generation_step
    import lgs_pkg::*;
#(
    parameter int GRID_ROWS = 64,
    parameter int GRID_COLS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_req_type,
    input  logic [5:0] i_row_index,
    input  logic [5:0] i_col_index,
    input  logic       i_write_value,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_done_type,
    output logic       o_read_value
);

    localparam int RW = $clog2(GRID_ROWS);
    localparam int CW = $clog2(GRID_COLS);
    localparam int XW = ((RW > 6) ? RW : 6) + 1;
    localparam logic [RW-1:0] LAST_ROW = RW'(GRID_ROWS - 1);

    logic [GRID_COLS-1:0] r_mem [GRID_ROWS];
    logic [GRID_COLS-1:0] r_rd_data;

    t_state               r_state, n_state;
    logic [RW-1:0]        r_row, n_row;
    logic                 r_out_valid, n_out_valid;
    logic [1:0]           r_done_type, n_done_type;
    logic                 r_read_value, n_read_value;
    t_req                 r_req, n_req;
    logic [RW-1:0]        r_addr, n_addr;
    logic [CW-1:0]        r_col, n_col;
    logic                 r_val, n_val;
    logic                 r_ingrid, n_ingrid;
    logic                 r_rd_bit, n_rd_bit;
    logic [GRID_COLS-1:0] r_prev, n_prev;
    logic [GRID_COLS-1:0] r_cur, n_cur;

    logic                 wr_en;
    logic [RW-1:0]        wr_addr;
    logic [GRID_COLS-1:0] wr_data;
    logic                 rd_en;
    logic [RW-1:0]        rd_addr;

    logic                 accept;
    logic [XW-1:0]        row_x;
    logic                 in_grid;
    logic [RW-1:0]        cell_addr;
    logic [CW-1:0]        cell_col;
    logic [RW:0]          row_plus2;
    logic [GRID_COLS-1:0] nxt;
    logic [GRID_COLS+1:0] pad_up, pad_mid, pad_dn;
    logic [3:0]           cnt [GRID_COLS];
    logic [GRID_COLS-1:0] new_row;
    logic [GRID_COLS-1:0] rmw_word;

    assign accept    = i_valid && o_ready;
    assign o_ready   = (r_state == S_IDLE);
    assign o_valid   = r_out_valid;
    assign o_done_type  = r_done_type;
    assign o_read_value = r_read_value;

    assign row_x     = XW'(i_row_index);
    assign in_grid   = (row_x < XW'(GRID_ROWS)) && ({1'b0, i_col_index} < 7'(GRID_COLS));
    assign cell_addr = row_x[RW-1:0];
    assign cell_col  = i_col_index[CW-1:0];
    assign row_plus2 = {1'b0, r_row} + (RW+1)'(2);

    assign nxt     = (r_row == LAST_ROW) ? '0 : r_rd_data;
    assign pad_up  = {1'b0, r_prev, 1'b0};
    assign pad_mid = {1'b0, r_cur, 1'b0};
    assign pad_dn  = {1'b0, nxt, 1'b0};

    always_comb begin
        for (int c = 0; c < GRID_COLS; c++) begin
            cnt[c] = {3'b0, pad_up[c]} + {3'b0, pad_up[c+1]} + {3'b0, pad_up[c+2]}
                   + {3'b0, pad_mid[c]} + {3'b0, pad_mid[c+2]}
                   + {3'b0, pad_dn[c]} + {3'b0, pad_dn[c+1]} + {3'b0, pad_dn[c+2]};
            new_row[c] = (cnt[c] == BIRTH_COUNT) || (r_cur[c] && (cnt[c] == STAY_MIN));
        end
    end

    always_comb begin
        rmw_word = r_rd_data;
        rmw_word[r_col] = r_val;
    end

    always_comb begin
        n_state      = r_state;
        n_row        = r_row;
        n_out_valid  = r_out_valid;
        n_done_type  = r_done_type;
        n_read_value = r_read_value;
        n_req        = r_req;
        n_addr       = r_addr;
        n_col        = r_col;
        n_val        = r_val;
        n_ingrid     = r_ingrid;
        n_rd_bit     = r_rd_bit;
        n_prev       = r_prev;
        n_cur        = r_cur;
        wr_en        = 1'b0;
        wr_addr      = r_row;
        wr_data      = '0;
        rd_en        = 1'b0;
        rd_addr      = r_row;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_INIT, S_CLEAR: begin
                wr_en = 1'b1;
                if (r_row == LAST_ROW) begin
                    n_state = (r_state == S_INIT) ? S_IDLE : S_FINISH;
                end else begin
                    n_row = r_row + RW'(1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_req    = t_req'(i_req_type);
                    n_addr   = cell_addr;
                    n_col    = cell_col;
                    n_val    = i_write_value;
                    n_ingrid = in_grid;
                    n_rd_bit = 1'b0;
                    n_row    = '0;
                    case (t_req'(i_req_type))
                        REQ_WRITE, REQ_READ: begin
                            rd_en   = in_grid;
                            rd_addr = cell_addr;
                            n_state = S_CELL;
                        end
                        REQ_ADVANCE: begin
                            rd_en   = 1'b1;
                            rd_addr = '0;
                            n_state = S_GEN_PRIME;
                        end
                        default: begin
                            n_state = S_CLEAR;
                        end
                    endcase
                end
            end
            S_CELL: begin
                if (r_req == REQ_WRITE) begin
                    wr_en   = r_ingrid;
                    wr_addr = r_addr;
                    wr_data = rmw_word;
                end else begin
                    n_rd_bit = r_ingrid && r_rd_data[r_col];
                end
                n_state = S_FINISH;
            end
            S_GEN_PRIME: begin
                n_prev  = '0;
                n_cur   = r_rd_data;
                rd_en   = 1'b1;
                rd_addr = RW'(1);
                n_state = S_GEN_RUN;
            end
            S_GEN_RUN: begin
                wr_en   = 1'b1;
                wr_data = new_row;
                n_prev  = r_cur;
                n_cur   = nxt;
                rd_en   = (row_plus2 < (RW+1)'(GRID_ROWS));
                rd_addr = row_plus2[RW-1:0];
                if (r_row == LAST_ROW) begin
                    n_state = S_FINISH;
                end else begin
                    n_row = r_row + RW'(1);
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_done_type  = r_req;
                    n_read_value = r_rd_bit;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
                n_row   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_done_type  <= n_done_type;
        r_read_value <= n_read_value;
        r_req        <= n_req;
        r_addr       <= n_addr;
        r_col        <= n_col;
        r_val        <= n_val;
        r_ingrid     <= n_ingrid;
        r_rd_bit     <= n_rd_bit;
        r_prev       <= n_prev;
        r_cur        <= n_cur;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_ready)
        else $error("block still ready after taking a word");

    a_gen_row_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GEN_RUN && r_row != LAST_ROW) |=>
            (r_state == S_GEN_RUN && r_row == $past(r_row) + RW'(1)))
        else $error("generation sweep skipped or stalled a row");

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_FINISH))
        else $error("result word loaded outside finish");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_FINISH) |-> !wr_en)
        else $error("grid written while no request in progress");

endmodule

// ===== tb/life_grid_checker.sv =====
module life_grid_checker
    import lgs_pkg::*;
#(
    parameter int GRID_ROWS = 64,
    parameter int GRID_COLS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [1:0] i_req_type,
    input  logic [5:0] i_row_index,
    input  logic [5:0] i_col_index,
    input  logic       i_write_value,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [1:0] i_done_type,
    input  logic       i_read_value,
    output int         o_pending,
    output int         o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_req kind;
        logic read_value;
    } t_life_result;

    t_life_result expected_results[$];
    logic [63:0]  grid_rows [GRID_ROWS];
    int           mismatches = 0;

    assign o_fail_count = mismatches;

    task automatic report_mismatch(input string what);
        if (mismatches < 40) begin
            $display("%0t ns: mismatch: %s", $realtime, what);
        end
        mismatches++;
    endtask

    function automatic void clear_grid();
        for (int r = 0; r < GRID_ROWS; r++) begin
            grid_rows[r] = '0;
        end
    endfunction

    function automatic void advance_grid();
        logic [63:0] next_rows [GRID_ROWS];
        int live;
        int rr;
        int cc;
        for (int r = 0; r < GRID_ROWS; r++) begin
            next_rows[r] = '0;
            for (int c = 0; c < GRID_COLS; c++) begin
                live = 0;
                for (int dr = -1; dr <= 1; dr++) begin
                    for (int dc = -1; dc <= 1; dc++) begin
                        rr = r + dr;
                        cc = c + dc;
                        if ((dr != 0 || dc != 0) && rr >= 0 && rr < GRID_ROWS &&
                            cc >= 0 && cc < GRID_COLS) begin
                            live += grid_rows[rr][cc];
                        end
                    end
                end
                if (grid_rows[r][c]) begin
                    next_rows[r][c] = (live == STAY_MIN) || (live == BIRTH_COUNT);
                end else begin
                    next_rows[r][c] = (live == BIRTH_COUNT);
                end
            end
        end
        grid_rows = next_rows;
    endfunction

    function automatic t_life_result predict_result(input t_req kind,
                                                    input logic [5:0] row,
                                                    input logic [5:0] col,
                                                    input logic val);
        t_life_result res;
        logic in_grid;
        in_grid = (int'(row) < GRID_ROWS) && (int'(col) < GRID_COLS);
        res.kind = kind;
        res.read_value = 1'b0;
        case (kind)
            REQ_WRITE: begin
                if (in_grid) begin
                    grid_rows[row][col] = val;
                end
            end
            REQ_READ: begin
                if (in_grid) begin
                    res.read_value = grid_rows[row][col];
                end
            end
            REQ_ADVANCE: begin
                advance_grid();
            end
            default: begin
                clear_grid();
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_life_result want;
        if (!i_rst_n) begin
            expected_results.delete();
            clear_grid();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result word type %0d with none expected",
                                              i_done_type));
                end else begin
                    want = expected_results.pop_front();
                    if (i_done_type !== want.kind) begin
                        report_mismatch($sformatf("done_type %0d, expected %0d",
                                                  i_done_type, want.kind));
                    end
                    if (i_read_value !== want.read_value) begin
                        report_mismatch($sformatf("read_value %0b, expected %0b (type %0d)",
                                                  i_read_value, want.read_value, want.kind));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(predict_result(t_req'(i_req_type), i_row_index,
                                                          i_col_index, i_write_value));
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lgs_pkg::*;

    localparam int GRID_ROWS = 64;
    localparam int GRID_COLS = 64;
    localparam int WORD_COUNT = 600;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [1:0] i_req_type = REQ_WRITE;
    logic [5:0] i_row_index = '0;
    logic [5:0] i_col_index = '0;
    logic       i_write_value = 1'b0;
    logic       i_ready = 1'b1;
    logic       o_ready;
    logic       o_valid;
    logic [1:0] o_done_type;
    logic       o_read_value;

    int pending_words;
    int fail_count;
    int words_sent = 0;
    bit calm = 1'b0;

    life_grid_generation_step #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_row_index   (i_row_index),
        .i_col_index   (i_col_index),
        .i_write_value (i_write_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_done_type   (o_done_type),
        .o_read_value  (o_read_value)
    );

    life_grid_checker #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_req_type    (i_req_type),
        .i_row_index   (i_row_index),
        .i_col_index   (i_col_index),
        .i_write_value (i_write_value),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_done_type   (o_done_type),
        .i_read_value  (o_read_value),
        .o_pending     (pending_words),
        .o_fail_count  (fail_count)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 7) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                i_ready <= 1'b1;
            end
        end
    end

    task automatic send_word(input t_req kind, input logic [5:0] row,
                             input logic [5:0] col, input logic val);
        i_valid       <= 1'b1;
        i_req_type    <= kind;
        i_row_index   <= row;
        i_col_index   <= col;
        i_write_value <= val;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        words_sent++;
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    function automatic logic [5:0] jitter_index(input int center);
        int idx;
        idx = center + $urandom_range(0, 8) - 4;
        if (idx < 0) idx = 0;
        if (idx > 63) idx = 63;
        return idx[5:0];
    endfunction

    initial begin
        int anchor_row;
        int anchor_col;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corner L-shapes grow into blocks, lone corner cell dies
        send_word(REQ_READ,    6'd0,  6'd0,  1'b1);
        send_word(REQ_WRITE,   6'd0,  6'd0,  1'b1);
        send_word(REQ_WRITE,   6'd0,  6'd1,  1'b1);
        send_word(REQ_WRITE,   6'd1,  6'd0,  1'b1);
        send_word(REQ_WRITE,   6'd63, 6'd63, 1'b1);
        send_word(REQ_WRITE,   6'd63, 6'd62, 1'b1);
        send_word(REQ_WRITE,   6'd62, 6'd63, 1'b1);
        send_word(REQ_WRITE,   6'd0,  6'd63, 1'b1);
        send_word(REQ_WRITE,   6'd63, 6'd0,  1'b1);
        send_word(REQ_WRITE,   6'd63, 6'd0,  1'b0);
        send_word(REQ_READ,    6'd63, 6'd63, 1'b0);
        send_word(REQ_ADVANCE, 6'd63, 6'd63, 1'b1);
        send_word(REQ_READ,    6'd1,  6'd1,  1'b0);
        send_word(REQ_READ,    6'd62, 6'd62, 1'b0);
        send_word(REQ_READ,    6'd0,  6'd63, 1'b0);
        send_word(REQ_READ,    6'd63, 6'd0,  1'b0);
        send_word(REQ_ADVANCE, 6'd0,  6'd0,  1'b0);
        send_word(REQ_READ,    6'd0,  6'd0,  1'b0);
        send_word(REQ_CLEAR,   6'd63, 6'd63, 1'b1);
        send_word(REQ_READ,    6'd1,  6'd1,  1'b0);
        send_word(REQ_READ,    6'd63, 6'd63, 1'b1);

        while (words_sent < WORD_COUNT) begin
            calm = (words_sent >= WORD_COUNT - 60);
            if ($urandom_range(0, 3) == 0) begin
                send_word(t_req'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                          6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
            end else begin
                // seed a patch near an anchor, evolve it, probe around it
                anchor_row = ($urandom_range(0, 3) == 0) ?
                             ($urandom_range(0, 1) ? 63 : 0) : $urandom_range(0, 63);
                anchor_col = ($urandom_range(0, 3) == 0) ?
                             ($urandom_range(0, 1) ? 63 : 0) : $urandom_range(0, 63);
                if ($urandom_range(0, 3) == 0) begin
                    send_word(REQ_CLEAR, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                              1'($urandom_range(0, 1)));
                end
                repeat ($urandom_range(4, 14)) begin
                    send_word(REQ_WRITE, jitter_index(anchor_row), jitter_index(anchor_col),
                              $urandom_range(0, 3) != 0);
                end
                repeat ($urandom_range(1, 3)) begin
                    send_word(REQ_ADVANCE, 6'($urandom_range(0, 63)),
                              6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
                    repeat ($urandom_range(2, 5)) begin
                        send_word(REQ_READ, jitter_index(anchor_row),
                                  jitter_index(anchor_col), 1'($urandom_range(0, 1)));
                    end
                end
            end
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
        repeat (GRID_ROWS + 16) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
